FILE: rtl/core/ectd_pkg.sv
// ----------------------------------------------------------------------------
// ectd_pkg
// shared types and constants for the epoch to calendar date converter
// ----------------------------------------------------------------------------
package ectd_pkg;

  localparam int PcW = 4;
  typedef logic [PcW-1:0] pc_t;

  // datapath operation of one microcode step
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_MUL,
    OP_SPLIT,
    OP_YEAR,
    OP_MONTH,
    OP_DONE
  } op_t;

  // branch condition, taken selects pc_taken, else pc_fall
  typedef enum logic [1:0] {
    C_ALWAYS,
    C_START,
    C_YEAR_FIT,
    C_MONTH_END
  } cond_t;

  // reciprocal constant selection
  typedef enum logic [1:0] {
    K_60,
    K_24,
    K_7
  } kon_t;

  // destination of a split step
  typedef enum logic [1:0] {
    D_SEC,
    D_MIN,
    D_HOUR,
    D_WDAY
  } dest_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    kon_t  kon;
    dest_t dest;
    pc_t   pc_taken;
    pc_t   pc_fall;
  } uword_t;

  typedef struct packed {
    logic start;
    logic year_fit;
    logic month_end;
  } flags_t;

  localparam logic [7:0] YearBase = 8'd70;
  localparam logic [2:0] WdayOffs = 3'd4;

  // reciprocal multipliers, exact for every 32-bit dividend but the 7 one, exact below 2^30 and fed one below 2^17
  function automatic logic [31:0] kmul(input kon_t k);
    logic [31:0] m;
    case (k)
      K_60:    m = 32'h8888_8889;  // shift 37
      K_24:    m = 32'hAAAA_AAAB;  // shift 36
      K_7:     m = 32'h2492_4925;  // shift 32, dividend below 2^17
      default: m = 32'h0;
    endcase
    return m;
  endfunction

  // days in a month, february by leap flag
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] l;
    case (mon)
      4'd0:    l = 5'd31;
      4'd1:    l = leap ? 5'd29 : 5'd28;
      4'd2:    l = 5'd31;
      4'd3:    l = 5'd30;
      4'd4:    l = 5'd31;
      4'd5:    l = 5'd30;
      4'd6:    l = 5'd31;
      4'd7:    l = 5'd31;
      4'd8:    l = 5'd30;
      4'd9:    l = 5'd31;
      4'd10:   l = 5'd30;
      4'd11:   l = 5'd31;
      default: l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

FILE: rtl/core/ectd_seq.sv
// ----------------------------------------------------------------------------
// ectd_seq
// microcode sequencer: step counter, control store and branch logic
// ----------------------------------------------------------------------------
module ectd_seq
  import ectd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output uword_t uw
);

  pc_t  pc_r;
  pc_t  pc_nxt;
  logic taken;

  // control store
  always_comb begin
    case (pc_r)
      4'd0:    uw = '{OP_IDLE,  C_START,     K_60, D_SEC,  4'd1,  4'd0};
      4'd1:    uw = '{OP_MUL,   C_ALWAYS,    K_60, D_SEC,  4'd2,  4'd2};
      4'd2:    uw = '{OP_SPLIT, C_ALWAYS,    K_60, D_SEC,  4'd3,  4'd3};
      4'd3:    uw = '{OP_MUL,   C_ALWAYS,    K_60, D_MIN,  4'd4,  4'd4};
      4'd4:    uw = '{OP_SPLIT, C_ALWAYS,    K_60, D_MIN,  4'd5,  4'd5};
      4'd5:    uw = '{OP_MUL,   C_ALWAYS,    K_24, D_HOUR, 4'd6,  4'd6};
      4'd6:    uw = '{OP_SPLIT, C_ALWAYS,    K_24, D_HOUR, 4'd7,  4'd7};
      4'd7:    uw = '{OP_MUL,   C_ALWAYS,    K_7,  D_WDAY, 4'd8,  4'd8};
      4'd8:    uw = '{OP_SPLIT, C_ALWAYS,    K_7,  D_WDAY, 4'd9,  4'd9};
      4'd9:    uw = '{OP_YEAR,  C_YEAR_FIT,  K_60, D_SEC,  4'd10, 4'd9};
      4'd10:   uw = '{OP_MONTH, C_MONTH_END, K_60, D_SEC,  4'd11, 4'd10};
      4'd11:   uw = '{OP_DONE,  C_ALWAYS,    K_60, D_SEC,  4'd0,  4'd0};
      default: uw = '{OP_IDLE,  C_ALWAYS,    K_60, D_SEC,  4'd0,  4'd0};
    endcase
  end

  always_comb begin
    case (uw.cond)
      C_ALWAYS:    taken = 1'b1;
      C_START:     taken = flags.start;
      C_YEAR_FIT:  taken = flags.year_fit;
      C_MONTH_END: taken = flags.month_end;
      default:     taken = 1'b1;
    endcase
  end

  always_comb begin
    pc_nxt = taken ? uw.pc_taken : uw.pc_fall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/core/epoch_to_calendar_date.sv
// ----------------------------------------------------------------------------
// epoch_to_calendar_date
// unix seconds to broken-down calendar time, microcoded datapath
// ----------------------------------------------------------------------------
//  channel   ports                          transfer when
//  input     start, busy, in_epoch_seconds  start high and busy low
//  result    out_valid, out_*               out_valid high, one cycle
//
//  from start to the out_valid strobe the sequencer runs its steps, with a
//  year loop over Y whole years past 1970 (up to 136), one year a cycle,
//  and a month loop over M whole months (up to 11)
//  synchronous active-low reset returns the sequencer to its idle step
//  the receiver cannot stall: each result is shown for one cycle only
// ----------------------------------------------------------------------------
module epoch_to_calendar_date
  import ectd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [2:0]  out_weekday,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [7:0]  out_year_since_1900
);

  uword_t uw;
  flags_t flags;

  // working value and product register
  logic [31:0] acc_r,  acc_nxt;
  logic [63:0] prod_r, prod_nxt;
  // remaining days, shrinks through the year and month loops
  logic [15:0] days_r, days_nxt;
  logic [5:0]  sec_r,  sec_nxt;
  logic [5:0]  min_r,  min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic [3:0]  mon_r,  mon_nxt;
  logic [7:0]  year_r, year_nxt;
  logic        valid_r, valid_nxt;

  logic [31:0] quot;
  logic [31:0] qd;
  logic [31:0] rmd;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  ectd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .uw    (uw)
  );

  // every year divisible by four is a leap year, 1900 base keeps the phase
  assign leap = (year_r[1:0] == 2'd0);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(mon_r, leap);

  assign busy = (uw.op != OP_IDLE);

  assign flags.start     = start;
  assign flags.year_fit  = (days_r < {7'd0, ylen});
  assign flags.month_end = (mon_r == 4'd11) || (days_r < {11'd0, mlen});

  // quotient from the reciprocal product, remainder by shift-and-add
  always_comb begin
    case (uw.kon)
      K_60: begin
        quot = {5'd0, prod_r[63:37]};
        qd   = (quot << 6) - (quot << 2);
      end
      K_24: begin
        quot = {4'd0, prod_r[63:36]};
        qd   = (quot << 4) + (quot << 3);
      end
      K_7: begin
        quot = prod_r[63:32];
        qd   = (quot << 3) - quot;
      end
      default: begin
        quot = '0;
        qd   = '0;
      end
    endcase
    rmd = acc_r - qd;
  end

  // datapath driven by the current control word
  always_comb begin
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    days_nxt  = days_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    wday_nxt  = wday_r;
    mon_nxt   = mon_r;
    year_nxt  = year_r;
    valid_nxt = 1'b0;
    case (uw.op)
      OP_IDLE: begin
        if (start) begin
          acc_nxt = in_epoch_seconds;
        end
      end
      OP_MUL: begin
        prod_nxt = acc_r * kmul(uw.kon);
      end
      OP_SPLIT: begin
        case (uw.dest)
          D_SEC: begin
            sec_nxt = rmd[5:0];
            acc_nxt = quot;
          end
          D_MIN: begin
            min_nxt = rmd[5:0];
            acc_nxt = quot;
          end
          D_HOUR: begin
            // day count goes to the loops, day count plus four to the weekday
            hour_nxt = rmd[4:0];
            days_nxt = quot[15:0];
            acc_nxt  = quot + {29'd0, WdayOffs};
            year_nxt = YearBase;
            mon_nxt  = '0;
          end
          D_WDAY: begin
            wday_nxt = rmd[2:0];
          end
          default: begin
            acc_nxt = acc_r;
          end
        endcase
      end
      OP_YEAR: begin
        if (!flags.year_fit) begin
          days_nxt = days_r - {7'd0, ylen};
          year_nxt = year_r + 8'd1;
        end
      end
      OP_MONTH: begin
        if (!flags.month_end) begin
          days_nxt = days_r - {11'd0, mlen};
          mon_nxt  = mon_r + 4'd1;
        end
      end
      OP_DONE: begin
        valid_nxt = 1'b1;
      end
      default: begin
        valid_nxt = 1'b0;
      end
    endcase
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    days_r <= days_nxt;
    sec_r  <= sec_nxt;
    min_r  <= min_nxt;
    hour_r <= hour_nxt;
    wday_r <= wday_nxt;
    mon_r  <= mon_nxt;
    year_r <= year_nxt;
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid           = valid_r;
  assign out_second          = sec_r;
  assign out_minute          = min_r;
  assign out_hour            = hour_r;
  assign out_weekday         = wday_r;
  assign out_month           = mon_r;
  assign out_day_of_month    = days_r[4:0] + 5'd1;
  assign out_year_since_1900 = year_r;

endmodule
